### rtl/core/moie_pkg.sv
// Shared types, codes and constants of the memory operand instruction executor.
package moie_pkg;

  localparam logic [3:0] OP_MOVE  = 4'd0;
  localparam logic [3:0] OP_ADD   = 4'd1;
  localparam logic [3:0] OP_SUB   = 4'd2;
  localparam logic [3:0] OP_MUL   = 4'd3;
  localparam logic [3:0] OP_DIV   = 4'd4;
  localparam logic [3:0] OP_LESS  = 4'd5;
  localparam logic [3:0] OP_EQUAL = 4'd6;
  localparam logic [3:0] OP_IF    = 4'd7;
  localparam logic [3:0] OP_GETC  = 4'd8;
  localparam logic [3:0] OP_GETI  = 4'd9;
  localparam logic [3:0] OP_PUTC  = 4'd10;
  localparam logic [3:0] OP_PUTI  = 4'd11;

  localparam logic [1:0] MODE_DIR = 2'd1;
  localparam logic [1:0] MODE_IND = 2'd2;

  localparam logic [2:0] ERR_NONE  = 3'd0;
  localparam logic [2:0] ERR_MEM   = 3'd1;
  localparam logic [2:0] ERR_CONST = 3'd2;
  localparam logic [2:0] ERR_DIV0  = 3'd3;
  localparam logic [2:0] ERR_JUMP  = 3'd4;
  localparam logic [2:0] ERR_END   = 3'd5;
  localparam logic [2:0] ERR_TIME  = 3'd6;

  localparam logic [7:0] CFG_PROGRAM_LENGTH = 8'd0;
  localparam logic [7:0] CFG_STEP_LIMIT     = 8'd1;

  localparam logic [30:0] STEP_LIMIT_RESET = 31'd10000000;

  typedef enum logic [3:0] {
    CK_NOP, CK_LOAD, CK_IMM, CK_RD_VAL, CK_RD_PTR, CK_CAP, CK_WR_VAL, CK_WR_PTR,
    CK_FAULT, CK_DIV, CK_COMPUTE, CK_JUDGE, CK_FINISH, CK_CLEAR
  } cmd_kind_t;

  typedef enum logic [1:0] {OPND_FIRST, OPND_SECOND, OPND_THIRD} opnd_t;

  typedef enum logic [1:0] {DST_X, DST_Y, DST_T, DST_P} dst_t;

  typedef struct packed {
    cmd_kind_t  kind;
    opnd_t      sel;
    dst_t       dst;
    logic [2:0] fault;
  } cmd_t;

  typedef struct packed {
    logic [3:0] opcode;
    logic [1:0] mode_first;
    logic [1:0] mode_second;
    logic [1:0] mode_third;
    logic       fault_any;
    logic       x_nonzero;
    logic       y_zero;
    logic       halted;
    logic       line_ok;
    logic       div_done;
    logic       clear_last;
    logic       result_busy;
  } status_t;

  typedef struct packed {
    logic [31:0] io_value;
    logic [31:0] value_third;
    logic [1:0]  mode_third;
    logic [31:0] value_second;
    logic [1:0]  mode_second;
    logic [31:0] value_first;
    logic [1:0]  mode_first;
    logic [3:0]  opcode;
  } item_t;

  typedef struct packed {
    logic [2:0]  error_code;
    logic [30:0] exit_code;
    logic        stopped;
    logic [31:0] out_value;
    logic        out_valid;
    logic [16:0] next_line;
    logic        out_kind;
  } result_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_R_START, S_R_CAP1, S_R_PTR, S_R_CAP2,
    S_W_START, S_W_CAP, S_W_PTR, S_MOV_W, S_AR2, S_AR3, S_DIV_WAIT,
    S_IF2, S_IF3, S_PUT2, S_FIN
  } state_t;

  function automatic logic is_imm(input logic [1:0] mode);
    return (mode != MODE_DIR) && (mode != MODE_IND);
  endfunction

endpackage

### rtl/core/moie_ram.sv
// Generic single-write, single-read RAM with registered read data.
module moie_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/moie_div.sv
// Iterative signed divider, one quotient bit per cycle, minus 1 on inexact negative dividend.
module moie_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        done,
  output logic [31:0] q
);

  logic        busy;
  logic        fix;
  logic [4:0]  cnt;
  logic [31:0] rem;
  logic [31:0] quo;
  logic [31:0] ub;
  logic        na;
  logic        nb;
  logic [32:0] rem_sh;
  logic [32:0] rem_sub;
  logic [31:0] q_sign;

  assign rem_sh  = {rem, quo[31]};
  assign rem_sub = rem_sh - {1'b0, ub};
  assign q_sign  = (na != nb) ? (32'd0 - quo) : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fix  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        fix  <= 1'b0;
      end else if (busy && cnt == 5'd31) begin
        busy <= 1'b0;
        fix  <= 1'b1;
      end else if (fix) begin
        fix  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      na  <= a[31];
      nb  <= b[31];
      quo <= a[31] ? (32'd0 - a) : a;
      ub  <= b[31] ? (32'd0 - b) : b;
      rem <= 32'd0;
      cnt <= 5'd0;
    end else if (busy) begin
      cnt <= cnt + 5'd1;
      if (!rem_sub[32]) begin
        rem <= rem_sub[31:0];
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= rem_sh[31:0];
        quo <= {quo[30:0], 1'b0};
      end
    end else if (fix) begin
      q <= (na && rem != 32'd0) ? (q_sign - 32'd1) : q_sign;
    end
  end

endmodule

### rtl/core/moie_ctrl.sv
// Instruction sequencer: operand fetch, store, divide wait and result hand-off.
module moie_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  moie_pkg::status_t status,
  output moie_pkg::cmd_t    cmd
);

  moie_pkg::state_t state, state_next;
  moie_pkg::state_t ret, ret_next;
  moie_pkg::opnd_t  rsel, rsel_next;
  moie_pkg::opnd_t  wsel, wsel_next;
  moie_pkg::dst_t   rdst, rdst_next;

  function automatic logic [1:0] mode_of(input moie_pkg::opnd_t sel,
                                         input moie_pkg::status_t st);
    logic [1:0] m;
    unique case (sel)
      moie_pkg::OPND_FIRST:  m = st.mode_first;
      moie_pkg::OPND_SECOND: m = st.mode_second;
      moie_pkg::OPND_THIRD:  m = st.mode_third;
      default:               m = st.mode_third;
    endcase
    return m;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= moie_pkg::S_CLEAR;
      ret   <= moie_pkg::S_IDLE;
      rsel  <= moie_pkg::OPND_FIRST;
      wsel  <= moie_pkg::OPND_FIRST;
      rdst  <= moie_pkg::DST_X;
    end else begin
      state <= state_next;
      ret   <= ret_next;
      rsel  <= rsel_next;
      wsel  <= wsel_next;
      rdst  <= rdst_next;
    end
  end

  always_comb begin
    state_next = state;
    ret_next   = ret;
    rsel_next  = rsel;
    wsel_next  = wsel;
    rdst_next  = rdst;
    in_ready   = 1'b0;
    cmd        = '{kind: moie_pkg::CK_NOP, sel: rsel, dst: rdst, fault: moie_pkg::ERR_NONE};
    unique case (state)
      moie_pkg::S_CLEAR: begin
        cmd.kind = moie_pkg::CK_CLEAR;
        if (status.clear_last) begin
          state_next = moie_pkg::S_IDLE;
        end
      end
      moie_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.kind   = moie_pkg::CK_LOAD;
          state_next = moie_pkg::S_DISPATCH;
        end
      end
      moie_pkg::S_DISPATCH: begin
        state_next = moie_pkg::S_FIN;
        if (status.halted) begin
          state_next = moie_pkg::S_FIN;
        end else if (!status.line_ok) begin
          cmd.kind  = moie_pkg::CK_FAULT;
          cmd.fault = moie_pkg::ERR_END;
        end else begin
          priority case (status.opcode)
            moie_pkg::OP_MOVE: begin
              if (moie_pkg::is_imm(status.mode_first)) begin
                cmd.kind  = moie_pkg::CK_FAULT;
                cmd.fault = moie_pkg::ERR_CONST;
              end else begin
                rsel_next  = moie_pkg::OPND_SECOND;
                rdst_next  = moie_pkg::DST_X;
                ret_next   = moie_pkg::S_MOV_W;
                state_next = moie_pkg::S_R_START;
              end
            end
            moie_pkg::OP_ADD, moie_pkg::OP_SUB, moie_pkg::OP_MUL, moie_pkg::OP_DIV,
            moie_pkg::OP_LESS, moie_pkg::OP_EQUAL: begin
              rsel_next  = moie_pkg::OPND_FIRST;
              rdst_next  = moie_pkg::DST_X;
              ret_next   = moie_pkg::S_AR2;
              state_next = moie_pkg::S_R_START;
            end
            moie_pkg::OP_IF: begin
              rsel_next  = moie_pkg::OPND_FIRST;
              rdst_next  = moie_pkg::DST_X;
              ret_next   = moie_pkg::S_IF2;
              state_next = moie_pkg::S_R_START;
            end
            moie_pkg::OP_GETC, moie_pkg::OP_GETI: begin
              cmd.kind   = moie_pkg::CK_COMPUTE;
              wsel_next  = moie_pkg::OPND_FIRST;
              state_next = moie_pkg::S_W_START;
            end
            moie_pkg::OP_PUTC, moie_pkg::OP_PUTI: begin
              rsel_next  = moie_pkg::OPND_FIRST;
              rdst_next  = moie_pkg::DST_X;
              ret_next   = moie_pkg::S_PUT2;
              state_next = moie_pkg::S_R_START;
            end
            default: begin
              cmd.kind  = moie_pkg::CK_FAULT;
              cmd.fault = moie_pkg::ERR_END;
            end
          endcase
        end
      end
      moie_pkg::S_R_START: begin
        if (moie_pkg::is_imm(mode_of(rsel, status))) begin
          cmd.kind   = moie_pkg::CK_IMM;
          state_next = ret;
        end else begin
          cmd.kind   = moie_pkg::CK_RD_VAL;
          state_next = moie_pkg::S_R_CAP1;
        end
      end
      moie_pkg::S_R_CAP1: begin
        cmd.kind = moie_pkg::CK_CAP;
        if (mode_of(rsel, status) == moie_pkg::MODE_IND) begin
          cmd.dst    = moie_pkg::DST_P;
          state_next = moie_pkg::S_R_PTR;
        end else begin
          state_next = ret;
        end
      end
      moie_pkg::S_R_PTR: begin
        if (status.fault_any) begin
          state_next = ret;
        end else begin
          cmd.kind   = moie_pkg::CK_RD_PTR;
          state_next = moie_pkg::S_R_CAP2;
        end
      end
      moie_pkg::S_R_CAP2: begin
        cmd.kind   = moie_pkg::CK_CAP;
        state_next = ret;
      end
      moie_pkg::S_W_START: begin
        cmd.sel = wsel;
        if (moie_pkg::is_imm(mode_of(wsel, status))) begin
          cmd.kind   = moie_pkg::CK_FAULT;
          cmd.fault  = moie_pkg::ERR_CONST;
          state_next = moie_pkg::S_FIN;
        end else if (mode_of(wsel, status) == moie_pkg::MODE_DIR) begin
          cmd.kind   = moie_pkg::CK_WR_VAL;
          state_next = moie_pkg::S_FIN;
        end else begin
          cmd.kind   = moie_pkg::CK_RD_VAL;
          state_next = moie_pkg::S_W_CAP;
        end
      end
      moie_pkg::S_W_CAP: begin
        cmd.kind   = moie_pkg::CK_CAP;
        cmd.dst    = moie_pkg::DST_P;
        state_next = moie_pkg::S_W_PTR;
      end
      moie_pkg::S_W_PTR: begin
        state_next = moie_pkg::S_FIN;
        if (!status.fault_any) begin
          cmd.kind = moie_pkg::CK_WR_PTR;
        end
      end
      moie_pkg::S_MOV_W: begin
        if (status.fault_any) begin
          state_next = moie_pkg::S_FIN;
        end else begin
          cmd.kind   = moie_pkg::CK_COMPUTE;
          wsel_next  = moie_pkg::OPND_FIRST;
          state_next = moie_pkg::S_W_START;
        end
      end
      moie_pkg::S_AR2: begin
        if (status.fault_any) begin
          state_next = moie_pkg::S_FIN;
        end else begin
          rsel_next  = moie_pkg::OPND_SECOND;
          rdst_next  = moie_pkg::DST_Y;
          ret_next   = moie_pkg::S_AR3;
          state_next = moie_pkg::S_R_START;
        end
      end
      moie_pkg::S_AR3: begin
        wsel_next = moie_pkg::OPND_THIRD;
        if (status.fault_any) begin
          state_next = moie_pkg::S_FIN;
        end else if (status.opcode == moie_pkg::OP_DIV) begin
          if (status.y_zero) begin
            cmd.kind   = moie_pkg::CK_FAULT;
            cmd.fault  = moie_pkg::ERR_DIV0;
            state_next = moie_pkg::S_FIN;
          end else begin
            cmd.kind   = moie_pkg::CK_DIV;
            state_next = moie_pkg::S_DIV_WAIT;
          end
        end else begin
          cmd.kind   = moie_pkg::CK_COMPUTE;
          state_next = moie_pkg::S_W_START;
        end
      end
      moie_pkg::S_DIV_WAIT: begin
        if (status.div_done) begin
          cmd.kind   = moie_pkg::CK_COMPUTE;
          state_next = moie_pkg::S_W_START;
        end
      end
      moie_pkg::S_IF2: begin
        if (status.fault_any || !status.x_nonzero) begin
          state_next = moie_pkg::S_FIN;
        end else begin
          rsel_next  = moie_pkg::OPND_SECOND;
          rdst_next  = moie_pkg::DST_T;
          ret_next   = moie_pkg::S_IF3;
          state_next = moie_pkg::S_R_START;
        end
      end
      moie_pkg::S_IF3: begin
        state_next = moie_pkg::S_FIN;
        if (!status.fault_any) begin
          cmd.kind = moie_pkg::CK_JUDGE;
        end
      end
      moie_pkg::S_PUT2: begin
        state_next = moie_pkg::S_FIN;
        if (!status.fault_any) begin
          cmd.kind = moie_pkg::CK_COMPUTE;
        end
      end
      moie_pkg::S_FIN: begin
        if (!status.result_busy) begin
          cmd.kind   = moie_pkg::CK_FINISH;
          state_next = moie_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = moie_pkg::S_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/moie_dp.sv
// Datapath: operand registers, word memory, divider, machine state and result register.
module moie_dp #(
  parameter int MEM_WORDS = 65536,
  parameter int MAX_LINES = 65536
) (
  input  logic              clk,
  input  logic              rst,
  input  moie_pkg::cmd_t    cmd,
  output moie_pkg::status_t status,
  input  moie_pkg::item_t   item,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  output moie_pkg::result_t result,
  output logic              result_valid,
  input  logic              result_ready
);

  localparam int AW = $clog2(MEM_WORDS);

  logic [16:0]     program_length;
  logic [30:0]     step_limit;
  moie_pkg::item_t ins;
  logic [31:0]     x, y, t, p, r;
  logic [2:0]      fault;
  logic            jumped, exited;
  logic [30:0]     exit_val;
  logic            outv, okind;
  logic [31:0]     oval;
  logic [16:0]     cur_line;
  logic [31:0]     step_count;
  logic            halted;
  logic [30:0]     held_exit;
  logic [2:0]      held_error;
  logic [AW-1:0]   clr_addr;

  logic [16:0]     len;
  logic [31:0]     vsel;
  logic [31:0]     a32;
  logic            in_range;
  logic            mem_access;
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [31:0]     ram_wdata;
  logic [31:0]     ram_rdata;
  logic            div_done;
  logic [31:0]     div_q;

  logic [16:0]     fin_line;
  logic [31:0]     fin_step;
  logic            fin_halted;
  logic [30:0]     fin_exit;
  logic [2:0]      fin_error;

  assign len = (32'(program_length) > 32'(MAX_LINES)) ? 17'(MAX_LINES) : program_length;

  always_comb begin
    unique case (cmd.sel)
      moie_pkg::OPND_FIRST:  vsel = ins.value_first;
      moie_pkg::OPND_SECOND: vsel = ins.value_second;
      moie_pkg::OPND_THIRD:  vsel = ins.value_third;
      default:               vsel = ins.value_third;
    endcase
  end

  assign a32 = (cmd.kind == moie_pkg::CK_RD_PTR || cmd.kind == moie_pkg::CK_WR_PTR) ? p : vsel;
  assign in_range   = a32 < 32'(MEM_WORDS);
  assign mem_access = cmd.kind == moie_pkg::CK_RD_VAL || cmd.kind == moie_pkg::CK_RD_PTR ||
                      cmd.kind == moie_pkg::CK_WR_VAL || cmd.kind == moie_pkg::CK_WR_PTR;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = a32[AW-1:0];
    ram_wdata = r;
    if (cmd.kind == moie_pkg::CK_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = 32'd0;
    end else if (cmd.kind == moie_pkg::CK_WR_VAL || cmd.kind == moie_pkg::CK_WR_PTR) begin
      ram_we = in_range;
    end
  end

  moie_ram #(
    .WIDTH(32),
    .DEPTH(MEM_WORDS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(a32[AW-1:0]),
    .rdata(ram_rdata)
  );

  moie_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.kind == moie_pkg::CK_DIV),
    .a    (x),
    .b    (y),
    .done (div_done),
    .q    (div_q)
  );

  always_comb begin
    fin_line   = cur_line;
    fin_step   = step_count;
    fin_halted = halted;
    fin_exit   = held_exit;
    fin_error  = held_error;
    if (!halted) begin
      if (exited) begin
        fin_halted = 1'b1;
        fin_exit   = exit_val;
        fin_error  = moie_pkg::ERR_NONE;
      end else if (fault != moie_pkg::ERR_NONE) begin
        fin_halted = 1'b1;
        fin_exit   = 31'd0;
        fin_error  = fault;
      end else begin
        fin_line = jumped ? t[16:0] : cur_line + 17'd1;
        fin_step = step_count + 32'd1;
        if (fin_step > {1'b0, step_limit}) begin
          fin_halted = 1'b1;
          fin_exit   = 31'd0;
          fin_error  = moie_pkg::ERR_TIME;
        end else if (fin_line > len) begin
          fin_halted = 1'b1;
          fin_exit   = 31'd0;
          fin_error  = moie_pkg::ERR_END;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      program_length <= 17'd0;
      step_limit     <= moie_pkg::STEP_LIMIT_RESET;
      cur_line       <= 17'd1;
      step_count     <= 32'd0;
      halted         <= 1'b0;
      held_exit      <= 31'd0;
      held_error     <= moie_pkg::ERR_NONE;
      clr_addr       <= '0;
      result_valid   <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == moie_pkg::CFG_PROGRAM_LENGTH) begin
        program_length <= cfg_data[16:0];
      end
      if (cfg_we && cfg_index == moie_pkg::CFG_STEP_LIMIT) begin
        step_limit <= cfg_data[30:0];
      end
      if (cmd.kind == moie_pkg::CK_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      if (cmd.kind == moie_pkg::CK_FINISH) begin
        cur_line     <= fin_line;
        step_count   <= fin_step;
        halted       <= fin_halted;
        held_exit    <= fin_exit;
        held_error   <= fin_error;
        result_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.kind)
      moie_pkg::CK_LOAD: begin
        ins    <= item;
        fault  <= moie_pkg::ERR_NONE;
        jumped <= 1'b0;
        exited <= 1'b0;
        outv   <= 1'b0;
        okind  <= 1'b0;
        oval   <= 32'd0;
      end
      moie_pkg::CK_IMM, moie_pkg::CK_CAP: begin
        unique case (cmd.dst)
          moie_pkg::DST_X: x <= (cmd.kind == moie_pkg::CK_IMM) ? vsel : ram_rdata;
          moie_pkg::DST_Y: y <= (cmd.kind == moie_pkg::CK_IMM) ? vsel : ram_rdata;
          moie_pkg::DST_T: t <= (cmd.kind == moie_pkg::CK_IMM) ? vsel : ram_rdata;
          moie_pkg::DST_P: p <= (cmd.kind == moie_pkg::CK_IMM) ? vsel : ram_rdata;
          default:         p <= ram_rdata;
        endcase
      end
      moie_pkg::CK_FAULT: begin
        if (fault == moie_pkg::ERR_NONE) begin
          fault <= cmd.fault;
        end
      end
      moie_pkg::CK_COMPUTE: begin
        priority case (ins.opcode)
          moie_pkg::OP_MOVE:  r <= x;
          moie_pkg::OP_ADD:   r <= x + y;
          moie_pkg::OP_SUB:   r <= x - y;
          moie_pkg::OP_MUL:   r <= x * y;
          moie_pkg::OP_DIV:   r <= div_q;
          moie_pkg::OP_LESS:  r <= {31'd0, $signed(x) < $signed(y)};
          moie_pkg::OP_EQUAL: r <= {31'd0, x == y};
          moie_pkg::OP_GETC, moie_pkg::OP_GETI: r <= ins.io_value;
          moie_pkg::OP_PUTC, moie_pkg::OP_PUTI: begin
            outv  <= 1'b1;
            okind <= ins.opcode == moie_pkg::OP_PUTI;
            oval  <= x;
          end
          default: r <= x;
        endcase
      end
      moie_pkg::CK_JUDGE: begin
        if (t[31]) begin
          exited   <= 1'b1;
          exit_val <= ~t[30:0];
        end else if (t != 32'd0 && t <= 32'(len)) begin
          jumped <= 1'b1;
        end else if (fault == moie_pkg::ERR_NONE) begin
          fault <= moie_pkg::ERR_JUMP;
        end
      end
      moie_pkg::CK_FINISH: begin
        result.next_line  <= fin_line;
        result.out_valid  <= outv;
        result.out_kind   <= okind;
        result.out_value  <= oval;
        result.stopped    <= fin_halted;
        result.exit_code  <= fin_halted ? fin_exit : 31'd0;
        result.error_code <= fin_halted ? fin_error : moie_pkg::ERR_NONE;
      end
      default: begin
      end
    endcase
    if (mem_access && !in_range && fault == moie_pkg::ERR_NONE) begin
      fault <= moie_pkg::ERR_MEM;
    end
  end

  assign status.opcode      = ins.opcode;
  assign status.mode_first  = ins.mode_first;
  assign status.mode_second = ins.mode_second;
  assign status.mode_third  = ins.mode_third;
  assign status.fault_any   = fault != moie_pkg::ERR_NONE;
  assign status.x_nonzero   = x != 32'd0;
  assign status.y_zero      = y == 32'd0;
  assign status.halted      = halted;
  assign status.line_ok     = cur_line != 17'd0 && cur_line <= len;
  assign status.div_done    = div_done;
  assign status.clear_last  = clr_addr == AW'(MEM_WORDS - 1);
  assign status.result_busy = result_valid;

endmodule

### rtl/core/memory_operand_instruction_executor.sv
// Top level of the memory operand instruction executor: stream ports, sequencer and datapath.
// One instruction beat in, one result beat out. After reset the word memory is swept to
// zero, one word a cycle, before the first beat is taken; configuration writes are taken
// at any time. An instruction passes the take, decode and finish steps plus its operand
// steps: an immediate is taken as it is, a direct read issues the address and captures the
// word, an indirect read does so for the pointer and then the word, a direct store writes at
// once, an indirect store captures the pointer and then writes, and a step lies between
// operands. A divide also waits for the bit-serial divider; the longest item is a divide with
// indirect sources and an indirect destination. The next instruction beat is taken while a
// result beat still waits; its result waits in turn until the output register is free.
module memory_operand_instruction_executor #(
  parameter int MEM_WORDS = 65536,
  parameter int MAX_LINES = 65536
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // opcode, mode_first, value_first, mode_second, value_second, mode_third,
  // value_third, io_value, zero pad
  input  logic [143:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // next_line, out_valid, out_value, stopped, exit_code, error_code, zero pad
  output logic [87:0]  m_tdata,
  // out_kind
  output logic         m_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  moie_pkg::cmd_t    cmd;
  moie_pkg::status_t status;
  moie_pkg::result_t res;

  assign cfg_ready = 1'b1;

  moie_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .status  (status),
    .cmd     (cmd)
  );

  moie_dp #(
    .MEM_WORDS(MEM_WORDS),
    .MAX_LINES(MAX_LINES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .item        (s_tdata[137:0]),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .result      (res),
    .result_valid(m_tvalid),
    .result_ready(m_tready)
  );

  assign m_tdata = {3'd0, res.error_code, res.exit_code, res.stopped, res.out_value,
                    res.out_valid, res.next_line};
  assign m_tuser = res.out_kind;

  a_out_stop: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res.out_valid && res.stopped |->
      res.error_code == moie_pkg::ERR_TIME || res.error_code == moie_pkg::ERR_END)
    else $error("output beat carries a stop other than time limit or end");

  a_no_out: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !res.out_valid |-> !res.out_kind && res.out_value == 32'd0)
    else $error("output kind or value set without output");

  a_running: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !res.stopped |-> res.exit_code == 31'd0 && res.error_code == moie_pkg::ERR_NONE)
    else $error("stop codes set while running");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid && !s_tready)
    else $error("beat moved right after reset");

endmodule

### tb/tb_top.sv
// Self-checking testbench for the memory operand instruction executor stream block.
`timescale 1ns / 1ps
module tb_top;
  import moie_pkg::*;

  localparam int MEMW = 65536;
  localparam int MAXL = 65536;
  localparam int WATCHDOG = 300000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [143:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [87:0]  m_tdata;
  logic         m_tuser;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [7:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;

  memory_operand_instruction_executor #(.MEM_WORDS(MEMW), .MAX_LINES(MAXL)) uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // shadow machine state
  logic [31:0] words [0:MEMW-1];
  logic [31:0] prog_len;
  logic [31:0] max_steps;
  logic [31:0] cur_line;
  logic [31:0] steps_done;
  bit          is_halted;
  logic [30:0] held_exit;
  logic [2:0]  held_err;
  logic [2:0]  flt;

  item_t   instr_q[$];
  result_t result_q[$];

  bit in_fire, out_fire, cfg_fire;
  bit burst;
  int in_gap, out_gap, idle_cnt;
  int errors;

  function automatic logic [31:0] load_word(logic [31:0] a);
    if (a >= MEMW) begin
      if (flt == ERR_NONE) flt = ERR_MEM;
      return '0;
    end
    return words[a];
  endfunction

  function automatic logic [31:0] read_opnd(logic [1:0] mode, logic [31:0] v);
    logic [31:0] p;
    if (mode == MODE_DIR) return load_word(v);
    if (mode == MODE_IND) begin
      p = load_word(v);
      if (flt != ERR_NONE) return '0;
      return load_word(p);
    end
    return v;
  endfunction

  function automatic void write_opnd(logic [1:0] mode, logic [31:0] v, logic [31:0] x,
                                     bit commit);
    logic [31:0] a;
    a = v;
    if (mode != MODE_DIR && mode != MODE_IND) begin
      if (flt == ERR_NONE) flt = ERR_CONST;
      return;
    end
    if (mode == MODE_IND) begin
      a = load_word(v);
      if (flt != ERR_NONE) return;
    end
    if (a >= MEMW) begin
      if (flt == ERR_NONE) flt = ERR_MEM;
      return;
    end
    if (commit) words[a] = x;
  endfunction

  function automatic logic [31:0] div_round_down(logic [31:0] a, logic [31:0] b);
    bit na, nb;
    logic [31:0] ua, ub, q, r, quot;
    na = a[31];
    nb = b[31];
    ua = na ? -a : a;
    ub = nb ? -b : b;
    q = ua / ub;
    r = ua % ub;
    quot = (na != nb) ? -q : q;
    if (na && r != 0) quot = quot - 1;
    return quot;
  endfunction

  // run one instruction; with commit clear only report whether it would keep running
  function automatic bit execute(item_t it, bit commit);
    logic [31:0] len, line, tgt, x, y, r, exitc, nl, oval;
    bit jumped, exited, outv, okind;
    result_t e;
    len = (prog_len < MAXL) ? prog_len : MAXL;
    line = cur_line;
    tgt = 0; x = 0; y = 0; r = 0; exitc = 0; oval = 0;
    jumped = 0; exited = 0; outv = 0; okind = 0;
    if (!is_halted) begin
      flt = ERR_NONE;
      if (line < 1 || line > len) begin
        flt = ERR_END;
      end else if (it.opcode == OP_MOVE) begin
        if (it.mode_first != MODE_DIR && it.mode_first != MODE_IND) flt = ERR_CONST;
        else begin
          x = read_opnd(it.mode_second, it.value_second);
          if (flt == ERR_NONE) write_opnd(it.mode_first, it.value_first, x, commit);
        end
      end else if (it.opcode >= OP_ADD && it.opcode <= OP_EQUAL) begin
        x = read_opnd(it.mode_first, it.value_first);
        if (flt == ERR_NONE) y = read_opnd(it.mode_second, it.value_second);
        if (flt == ERR_NONE) begin
          case (it.opcode)
            OP_ADD: r = x + y;
            OP_SUB: r = x - y;
            OP_MUL: r = x * y;
            OP_DIV: begin
              if (y == 0) flt = ERR_DIV0;
              else r = div_round_down(x, y);
            end
            OP_LESS: r = ($signed(x) < $signed(y)) ? 1 : 0;
            default: r = (x == y) ? 1 : 0;
          endcase
        end
        if (flt == ERR_NONE) write_opnd(it.mode_third, it.value_third, r, commit);
      end else if (it.opcode == OP_IF) begin
        x = read_opnd(it.mode_first, it.value_first);
        if (flt == ERR_NONE && x != 0) begin
          tgt = read_opnd(it.mode_second, it.value_second);
          if (flt == ERR_NONE) begin
            if (tgt[31]) begin
              exited = 1;
              exitc = 32'hFFFF_FFFF - tgt;
            end else if (tgt >= 1 && tgt <= len) jumped = 1;
            else flt = ERR_JUMP;
          end
        end
      end else if (it.opcode == OP_GETC || it.opcode == OP_GETI) begin
        write_opnd(it.mode_first, it.value_first, it.io_value, commit);
      end else if (it.opcode == OP_PUTC || it.opcode == OP_PUTI) begin
        x = read_opnd(it.mode_first, it.value_first);
        if (flt == ERR_NONE) begin
          outv = 1;
          okind = (it.opcode == OP_PUTI);
          oval = x;
        end
      end else begin
        flt = ERR_END;
      end
      nl = jumped ? tgt : line + 1;
      if (!exited && flt == ERR_NONE) begin
        if (steps_done + 1 > max_steps) flt = ERR_TIME;
        else if (nl > len) flt = ERR_END;
      end
      if (!commit) return !(exited || flt != ERR_NONE);
      if (exited) begin
        is_halted = 1;
        held_exit = exitc[30:0];
        held_err = ERR_NONE;
      end else if (flt == ERR_JUMP || flt == ERR_MEM || flt == ERR_CONST ||
                   flt == ERR_DIV0 || (flt == ERR_END && (line < 1 || line > len ||
                   it.opcode > OP_PUTI))) begin
        is_halted = 1;
        held_exit = '0;
        held_err = flt;
      end else begin
        cur_line = nl;
        steps_done = steps_done + 1;
        if (flt != ERR_NONE) begin
          is_halted = 1;
          held_exit = '0;
          held_err = flt;
        end
      end
    end else if (!commit) return 0;
    e.next_line = cur_line[16:0];
    e.out_valid = outv;
    e.out_kind = outv ? okind : 1'b0;
    e.out_value = outv ? oval : '0;
    e.stopped = is_halted;
    e.exit_code = is_halted ? held_exit : '0;
    e.error_code = is_halted ? held_err : ERR_NONE;
    result_q = {result_q, e};
    return !is_halted;
  endfunction

  function automatic item_t mk(logic [3:0] op, logic [1:0] mf, logic [31:0] vf,
                               logic [1:0] ms, logic [31:0] vs, logic [1:0] mt,
                               logic [31:0] vt, logic [31:0] io);
    item_t it;
    it.opcode = op;
    it.mode_first = mf; it.value_first = vf;
    it.mode_second = ms; it.value_second = vs;
    it.mode_third = mt; it.value_third = vt;
    it.io_value = io;
    return it;
  endfunction

  function automatic void issue(item_t it);
    void'(execute(it, 1));
    instr_q = {instr_q, it};
  endfunction

  function automatic logic [31:0] pick_val(logic [1:0] mode);
    int k;
    k = $urandom_range(0, 19);
    if (mode == MODE_DIR || mode == MODE_IND) begin
      if (k == 0) return MEMW - 1;
      if (k == 1) return 0;
      return $urandom_range(0, 31);
    end
    if (k < 8) return $urandom_range(0, 31);
    if (k == 8) return 32'h8000_0000;
    if (k == 9) return 32'h7FFF_FFFF;
    if (k == 10) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  function automatic item_t rand_item();
    item_t it;
    it.opcode = 4'($urandom_range(0, 11));
    it.mode_first = 2'($urandom_range(0, 3));
    it.mode_second = 2'($urandom_range(0, 3));
    it.mode_third = 2'($urandom_range(0, 3));
    if ((it.opcode == OP_MOVE || it.opcode == OP_GETC || it.opcode == OP_GETI ||
         (it.opcode >= OP_ADD && it.opcode <= OP_EQUAL)) && $urandom_range(0, 9) != 0) begin
      it.mode_first = (it.opcode >= OP_ADD && it.opcode <= OP_EQUAL) ?
                      it.mode_first : 2'($urandom_range(1, 2));
      it.mode_third = 2'($urandom_range(1, 2));
    end
    it.value_first = pick_val(it.mode_first);
    it.value_second = pick_val(it.mode_second);
    it.value_third = pick_val(it.mode_third);
    it.io_value = (it.opcode == OP_GETC && $urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF
                                                                       : $urandom;
    if (it.opcode == OP_IF && $urandom_range(0, 3) != 0) begin
      it.mode_second = 2'd0;
      it.value_second = $urandom_range(1, 30);
    end
    if (cur_line > 150)
      it = mk(OP_IF, 2'd0, 1, 2'd0, $urandom_range(1, 20), 2'd0, $urandom, $urandom);
    return it;
  endfunction

  function automatic void issue_random();
    item_t it;
    int n;
    for (n = 0; n < 30; n++) begin
      it = rand_item();
      if (execute(it, 0)) break;
    end
    if (n == 30) it = mk(OP_PUTI, 2'd0, $urandom, 2'd0, 0, 2'd0, 0, 0);
    issue(it);
  endfunction

  task automatic drain();
    while (instr_q.size() != 0 || result_q.size() != 0) @(negedge clk);
  endtask

  task automatic cfg_write(logic [7:0] idx, logic [31:0] val);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(negedge clk); while (!cfg_fire);
    cfg_valid <= 1'b0;
    if (idx == CFG_PROGRAM_LENGTH) prog_len = val & 32'h1FFFF;
    else if (idx == CFG_STEP_LIMIT) max_steps = val & 32'h7FFF_FFFF;
  endtask

  // stimulus and phase sequencing
  initial begin
    int i, ph, fin;
    logic [31:0] lens [4];
    logic [31:0] lims [4];
    for (i = 0; i < MEMW; i++) words[i] = '0;
    prog_len = 0; max_steps = STEP_LIMIT_RESET; cur_line = 1; steps_done = 0;
    is_halted = 0; held_exit = '0; held_err = ERR_NONE; errors = 0; burst = 0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    cfg_write(CFG_PROGRAM_LENGTH, MAXL);
    cfg_write(CFG_STEP_LIMIT, 32'h7FFF_FFFF);
    issue(mk(OP_GETC, MODE_DIR, 0, 2'd0, 0, 2'd0, 0, 32'hFFFF_FFFF));
    issue(mk(OP_GETI, MODE_DIR, 1, 2'd0, 0, 2'd0, 0, 32'h8000_0000));
    issue(mk(OP_GETI, MODE_DIR, 2, 2'd0, 0, 2'd0, 0, 32'h7FFF_FFFF));
    issue(mk(OP_MOVE, MODE_DIR, 3, 2'd0, MEMW - 1, 2'd0, 0, 0));
    issue(mk(OP_MOVE, MODE_DIR, MEMW - 1, 2'd0, 32'h5555_AAAA, 2'd0, 0, 0));
    issue(mk(OP_PUTI, MODE_IND, 3, 2'd0, 0, 2'd0, 0, 0));
    issue(mk(OP_ADD, MODE_DIR, 1, MODE_DIR, 2, MODE_DIR, 4, 0));
    issue(mk(OP_SUB, MODE_DIR, 1, 2'd0, 1, MODE_DIR, 5, 0));
    issue(mk(OP_MUL, MODE_DIR, 2, MODE_DIR, 2, MODE_DIR, 6, 0));
    issue(mk(OP_DIV, 2'd0, 32'h8000_0000, 2'd0, 32'hFFFF_FFFF, MODE_DIR, 7, 0));
    issue(mk(OP_DIV, 2'd0, -32'sd7, 2'd0, 2, MODE_DIR, 8, 0));
    issue(mk(OP_DIV, 2'd0, 7, 2'd0, -32'sd2, MODE_DIR, 9, 0));
    issue(mk(OP_DIV, 2'd0, -32'sd8, 2'd0, -32'sd2, MODE_IND, 3, 0));
    issue(mk(OP_LESS, 2'd0, 32'h8000_0000, 2'd0, 32'h7FFF_FFFF, MODE_DIR, 10, 0));
    issue(mk(OP_LESS, 2'd0, 32'h7FFF_FFFF, 2'd3, 32'h8000_0000, MODE_DIR, 11, 0));
    issue(mk(OP_EQUAL, MODE_DIR, 1, 2'd0, 32'h8000_0000, MODE_DIR, 12, 0));
    issue(mk(OP_PUTC, MODE_DIR, 0, 2'd0, 0, 2'd0, 0, 0));
    issue(mk(OP_PUTC, 2'd3, 32'h0000_01C1, 2'd0, 0, 2'd0, 0, 0));
    issue(mk(OP_PUTI, MODE_DIR, 4, 2'd0, 0, 2'd0, 0, 0));
    issue(mk(OP_IF, 2'd0, 0, MODE_IND, 32'h7FFF_FFFF, 2'd0, 0, 0));
    issue(mk(OP_IF, MODE_DIR, 12, 2'd0, 3, 2'd0, 0, 0));
    issue(mk(OP_IF, 2'd0, 1, MODE_DIR, 10, 2'd0, 0, 0));
    lens[0] = 32'h1FFFF; lens[1] = MAXL - 1; lens[2] = 1000; lens[3] = MAXL;
    lims[0] = STEP_LIMIT_RESET; lims[1] = 32'h7FFF_FFFF; lims[2] = 5000; lims[3] = 2000000;
    for (ph = 0; ph < 4; ph++) begin
      drain();
      cfg_write(CFG_PROGRAM_LENGTH, lens[ph]);
      cfg_write(CFG_STEP_LIMIT, lims[ph]);
      burst = (ph == 1);
      for (i = 0; i < 245; i++) issue_random();
    end
    burst = 0;
    fin = $urandom_range(0, 9);
    case (fin)
      0: issue(mk(OP_ADD, MODE_DIR, MEMW, 2'd0, 1, MODE_DIR, 0, 0));
      1: issue(mk(OP_MOVE, 2'd0, 5, 2'd0, 1, 2'd0, 0, 0));
      2: issue(mk(OP_DIV, 2'd0, 9, 2'd0, 0, 2'd0, 0, 0));
      3: issue(mk(OP_IF, 2'd0, 1, 2'd0, $urandom_range(0, 1) ? 0 : prog_len + 1, 2'd0, 0, 0));
      4: issue(mk(4'($urandom_range(12, 15)), 2'd0, 0, 2'd0, 0, 2'd0, 0, 0));
      5: issue(mk(OP_IF, 2'd0, 1, 2'd0, $urandom_range(0, 1) ? 32'hFFFF_FFFF
                                                             : ($urandom | 32'h8000_0000),
                  2'd0, 0, 0));
      6: begin
        cfg_write(CFG_STEP_LIMIT, 1);
        issue(mk(OP_PUTI, 2'd0, 77, 2'd0, 0, 2'd0, 0, 0));
      end
      7: begin
        cfg_write(CFG_PROGRAM_LENGTH, 0);
        issue(mk(OP_PUTC, 2'd0, 65, 2'd0, 0, 2'd0, 0, 0));
      end
      8: begin
        cfg_write(CFG_PROGRAM_LENGTH, cur_line);
        issue(mk(OP_PUTC, 2'd0, 66, 2'd0, 0, 2'd0, 0, 0));
      end
      default: begin
        issue(mk(OP_GETI, MODE_DIR, 40, 2'd0, 0, 2'd0, 0, 32'h8000_0000));
        issue(mk(OP_PUTI, MODE_IND, 40, 2'd0, 0, 2'd0, 0, 0));
      end
    endcase
    for (i = 0; i < 4; i++)
      issue(mk(4'($urandom), 2'($urandom), $urandom, 2'($urandom), $urandom, 2'($urandom),
               $urandom, $urandom));
    drain();
    repeat (100) @(negedge clk);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  function automatic int pick_gap();
    int k;
    if (burst) return 0;
    k = $urandom_range(0, 99);
    if (k < 60) return 0;
    if (k < 95) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  // instruction driver and result ready pacing
  always @(negedge clk) begin
    if (!rst) begin
      if (!s_tvalid || in_fire) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          s_tvalid <= 1'b0;
        end else if (instr_q.size() != 0) begin
          s_tdata <= {6'b0, instr_q.pop_front()};
          s_tvalid <= 1'b1;
          in_gap <= pick_gap();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (out_fire || !m_tready) out_gap <= pick_gap();
      end
    end
  end

  // result monitor and watchdog
  always @(posedge clk) begin
    result_t e;
    in_fire <= s_tvalid && s_tready;
    out_fire <= m_tvalid && m_tready;
    cfg_fire <= cfg_valid && cfg_ready;
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt > WATCHDOG) begin
      $display("TB_ERROR");
      $finish;
    end
    if (!rst && m_tvalid && m_tready) begin
      if (result_q.size() == 0) begin
        $error("unexpected result beat %h", m_tdata);
        errors = errors + 1;
      end else begin
        e = result_q.pop_front();
        if (m_tdata[16:0] != e.next_line) begin
          $error("next_line exp %0d got %0d", e.next_line, m_tdata[16:0]);
          errors = errors + 1;
        end
        if (m_tdata[17] != e.out_valid) begin
          $error("out_valid exp %0d got %0d", e.out_valid, m_tdata[17]);
          errors = errors + 1;
        end
        if (m_tuser != e.out_kind) begin
          $error("out_kind exp %0d got %0d", e.out_kind, m_tuser);
          errors = errors + 1;
        end
        if (m_tdata[49:18] != e.out_value) begin
          $error("out_value exp %h got %h", e.out_value, m_tdata[49:18]);
          errors = errors + 1;
        end
        if (m_tdata[50] != e.stopped) begin
          $error("stopped exp %0d got %0d", e.stopped, m_tdata[50]);
          errors = errors + 1;
        end
        if (m_tdata[81:51] != e.exit_code) begin
          $error("exit_code exp %0d got %0d", e.exit_code, m_tdata[81:51]);
          errors = errors + 1;
        end
        if (m_tdata[84:82] != e.error_code) begin
          $error("error_code exp %0d got %0d", e.error_code, m_tdata[84:82]);
          errors = errors + 1;
        end
      end
    end
  end

  initial begin
    in_gap = 0;
    out_gap = 0;
    idle_cnt = 0;
    in_fire = 0;
    out_fire = 0;
    cfg_fire = 0;
  end

endmodule
